/* sv/shdf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shdf_pkg: shared types and constants of the sync header frame deframer
// Holds the hunt state encoding, the header byte values and the result word
// that passes from the frame tracker to the output stage.
// ----------------------------------------------------------------------------
package shdf_pkg;

  localparam logic [7:0] SYNC_U = 8'h55;
  localparam logic [7:0] SYNC_N = 8'h4E;
  localparam logic [7:0] SYNC_E = 8'h45;
  localparam logic [7:0] SYNC_R = 8'h52;
  localparam logic [7:0] COLON  = 8'h3A;

  // Checksum seed without the length byte
  localparam logic [7:0] HDR_XOR = SYNC_U ^ SYNC_N ^ SYNC_E ^ SYNC_R ^ COLON;

  typedef enum logic [2:0] {
    HUNT_U     = 3'd0,
    HUNT_N     = 3'd1,
    HUNT_E     = 3'd2,
    HUNT_R     = 3'd3,
    HUNT_LEN   = 3'd4,
    HUNT_COLON = 3'd5,
    HUNT_DATA  = 3'd6
  } hunt_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       ok;
  } shdf_res_t;

endpackage : shdf_pkg
`default_nettype wire

/* sv/sync_header_frame_deframer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sync_header_frame_deframer: sync header frame deframer with XOR checksum
// Strips the "UNER" header, length and colon from a byte stream, passes the
// payload words on and closes each frame with a checksum verdict.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata        | tlast      | tuser
//  --------+-----------+--------------+------------+----------
//  in_     | slave     | rx_byte[7:0] | -          | -
//  out_    | master    | data_byte    | frame_end  | frame_ok
//
//  One word per cycle sustained while the output is not stalled: an accepted
//  word is held in the input register while the frame tracker decides on it,
//  and a result then enters the output register.
//  rst_n is synchronous, active low; it clears both valid flags and returns
//  the hunt to waiting for the first sync byte.
//  A stalled output holds the input register; words that produce no result
//  still wait for that slot, so backpressure reaches in_tready combinationally.
// ----------------------------------------------------------------------------
module sync_header_frame_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] rx_byte
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata,  // [7:0] data_byte
  output      logic       out_tlast,  // frame_end
  output      logic       out_tuser   // [0] frame_ok
);
  import shdf_pkg::*;

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_data_r;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic       out_ok_r;

  logic      advance;
  logic      step;
  shdf_res_t res;

  // Advance the held word whenever the output slot is free or being drained
  assign advance   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  shdf_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_data_r),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture only, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
    end
    if (step && res.valid) begin
      out_data_r <= res.data;
      out_last_r <= res.last;
      out_ok_r   <= res.ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ok_r;

  // A good-checksum flag only rides on a frame end word
  a_ok_only_on_end : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser || out_tlast))
    else $error("frame_ok set on a payload word");

  // A held input word stays put while the output slot is blocked
  a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("input register lost a word during an output stall");

  // Every result the tracker produces lands in the output register
  a_result_lands : assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.valid) |=> out_valid_r)
    else $error("result dropped on its way to the output register");

endmodule : sync_header_frame_deframer
`default_nettype wire

/* sv/shdf_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shdf_core: frame tracker
// Hunts for the sync header, counts the payload, keeps the running checksum
// and forms the result word for the byte presented on rx_byte.
// ----------------------------------------------------------------------------
module shdf_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          rx_byte,
  output shdf_pkg::shdf_res_t      res
);
  import shdf_pkg::*;

  hunt_t      state_r, state_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] xor_r, xor_nxt;
  hunt_t      restart;

  assign restart = (rx_byte == SYNC_U) ? HUNT_N : HUNT_U;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HUNT_U;
      cnt_r   <= 8'd0;
      xor_r   <= 8'd0;
    end else if (step) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    res       = '{valid: 1'b0, data: rx_byte, last: 1'b0, ok: 1'b0};
    case (state_r)
      HUNT_U: begin
        state_nxt = restart;
      end
      HUNT_N: begin
        state_nxt = (rx_byte == SYNC_N) ? HUNT_E : restart;
      end
      HUNT_E: begin
        state_nxt = (rx_byte == SYNC_E) ? HUNT_R : restart;
      end
      HUNT_R: begin
        state_nxt = (rx_byte == SYNC_R) ? HUNT_LEN : restart;
      end
      HUNT_LEN: begin
        cnt_nxt   = rx_byte;
        state_nxt = HUNT_COLON;
      end
      HUNT_COLON: begin
        if (rx_byte == COLON) begin
          xor_nxt   = HDR_XOR ^ cnt_r;
          state_nxt = HUNT_DATA;
        end else begin
          state_nxt = restart;
        end
      end
      HUNT_DATA: begin
        cnt_nxt   = cnt_r - 8'd1;
        res.valid = 1'b1;
        if (cnt_r != 8'd1) begin
          xor_nxt = xor_r ^ rx_byte;
        end else begin
          // checksum byte closes the frame and is rechecked as a sync start
          res.last  = 1'b1;
          res.ok    = (xor_r == rx_byte);
          state_nxt = restart;
        end
      end
      default: begin
        state_nxt = HUNT_U;
      end
    endcase
  end

endmodule : shdf_core
`default_nettype wire

/* tb/tb_sync_header_frame_deframer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sync_header_frame_deframer: self-checking bench for the frame deframer
// Feeds byte words holding "UNER" frames, broken headers and line noise,
// tracks the hunt in a behavioral copy of the deframer and checks every
// payload and frame-end word against it, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_sync_header_frame_deframer;
  import shdf_pkg::*;

  // Stop the run when this many cycles pass without any word moving
  localparam int STALL_LIMIT  = 2000;
  // Cycles to linger after the last expected word
  localparam int DRAIN_CYCLES = 12;
  // Approximate stream length in bytes
  localparam int TOTAL_BYTES  = 1150;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ok;
  } out_word_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] rx_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] data_byte
  logic       out_tlast;           // frame_end
  logic       out_tuser;           // [0] frame_ok

  sync_header_frame_deframer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Bytes waiting to go out, with a flag per byte that holds it back until
  // every result owed so far has come out of the block
  logic [7:0] tx_bytes [$];
  bit         tx_hold  [$];
  // Payload and frame-end words the deframer owes, oldest first
  out_word_t  due_words [$];

  // Behavioral copy of the hunt
  hunt_t      trk_state = HUNT_U;
  logic [7:0] trk_left  = 8'h00;
  logic [7:0] trk_xor   = 8'h00;

  int err_count    = 0;
  int bytes_taken  = 0;
  int bytes_loaded = 0;
  int words_seen   = 0;
  int frames_good  = 0;
  int frames_bad   = 0;
  int tx_wait      = 0;
  int rx_wait      = 0;
  int idle_cycles  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Deframer tracking
  // --------------------------------------------------------------------------

  // Look at a byte as a possible start of the sync sequence
  function automatic hunt_t sync_start(input logic [7:0] b);
    return (b == SYNC_U) ? HUNT_N : HUNT_U;
  endfunction

  // Advance the hunt by one accepted byte and queue the word, if any, that it produces
  task automatic track_byte(input logic [7:0] b);
    out_word_t w;
    case (trk_state)
      HUNT_U:     trk_state = sync_start(b);
      HUNT_N:     trk_state = (b == SYNC_N) ? HUNT_E : sync_start(b);
      HUNT_E:     trk_state = (b == SYNC_E) ? HUNT_R : sync_start(b);
      HUNT_R:     trk_state = (b == SYNC_R) ? HUNT_LEN : sync_start(b);
      HUNT_LEN: begin
        trk_left  = b;
        trk_state = HUNT_COLON;
      end
      HUNT_COLON: begin
        if (b == COLON) begin
          trk_xor   = HDR_XOR ^ trk_left;
          trk_state = HUNT_DATA;
        end else begin
          trk_state = sync_start(b);
        end
      end
      HUNT_DATA: begin
        // A length of zero wraps here, leaving 255 payload words
        trk_left = trk_left - 8'd1;
        w.data   = b;
        if (trk_left != 8'd0) begin
          trk_xor = trk_xor ^ b;
          w.last  = 1'b0;
          w.ok    = 1'b0;
        end else begin
          // Checksum word: close the frame, then retry it as a sync start
          w.last    = 1'b1;
          w.ok      = (trk_xor == b);
          trk_state = sync_start(b);
        end
        due_words.push_back(w);
      end
      default:    trk_state = HUNT_U;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b, input bit hold = 1'b0);
    tx_bytes.push_back(b);
    tx_hold.push_back(hold);
  endtask

  // Queue one full frame; length 0 means 255 payload bytes
  task automatic push_frame(input logic [7:0] len, input bit good, input bit hold);
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    int         fill;
    sum  = HDR_XOR ^ len;
    n    = (len == 8'd0) ? 255 : int'(len) - 1;
    fill = $urandom_range(0, 5);
    push_byte(SYNC_U, hold);
    push_byte(SYNC_N);
    push_byte(SYNC_E);
    push_byte(SYNC_R);
    push_byte(len);
    push_byte(COLON);
    for (int i = 0; i < n; i++) begin
      case (fill)
        0:       b = 8'h00;
        1:       b = 8'hFF;
        2:       b = (i % 2) ? SYNC_U : SYNC_N;  // header-like bytes inside payload
        default: b = 8'($urandom_range(0, 255));
      endcase
      sum = sum ^ b;
      push_byte(b);
    end
    push_byte(good ? sum : (sum ^ 8'($urandom_range(1, 255))));
  endtask

  // Queue a header cut short by a wrong byte
  task automatic push_broken_header();
    logic [7:0] hdr [4];
    logic [7:0] want;
    logic [7:0] b;
    int         k;
    hdr = '{SYNC_U, SYNC_N, SYNC_E, SYNC_R};
    k   = $urandom_range(1, 4);
    for (int i = 0; i < k; i++) begin
      push_byte(hdr[i]);
    end
    if (k == 4) begin
      push_byte(8'($urandom_range(0, 255)));
      want = COLON;
    end else begin
      want = hdr[k];
    end
    // Break it, often with a 'U' that restarts the hunt on the spot
    if ($urandom_range(0, 9) < 4) begin
      b = SYNC_U;
    end else begin
      do begin
        b = 8'($urandom_range(0, 255));
      end while (b == want);
    end
    push_byte(b);
  endtask

  task automatic build_stimulus();
    int r;
    int len;
    int frames;
    // Directed: noise extremes, mismatches on 'N', 'R' and ':' by a 'U',
    // a checksum word that reads as 'U' and opens the next header, a
    // length-one frame, and a short frame with extreme payload values.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(SYNC_U);
    push_byte(SYNC_U);
    push_byte(SYNC_N);
    push_byte(SYNC_E);
    push_byte(SYNC_U);
    push_byte(SYNC_N);
    push_byte(SYNC_E);
    push_byte(SYNC_R);
    push_byte(8'h02);
    push_byte(SYNC_U);
    push_byte(SYNC_N);
    push_byte(SYNC_E);
    push_byte(SYNC_R);
    push_byte(8'h01);
    push_byte(COLON);
    push_byte(SYNC_U);
    push_byte(SYNC_N);
    push_byte(SYNC_E);
    push_byte(SYNC_R);
    push_byte(8'h03);
    push_byte(COLON);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(HDR_XOR ^ 8'h03 ^ 8'h00 ^ 8'hFF);
    push_frame(8'h01, 1'b1, 1'b0);

    // Random: mostly well-formed frames, the rest noise and broken headers.
    // The first frame carries the wrapping zero length and waits for the
    // pipeline to drain before it starts.
    push_frame(8'h00, 1'b1, 1'b1);
    frames = 1;
    while (tx_bytes.size() < TOTAL_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 9) < 9) begin
          len = $urandom_range(1, 12);
        end else begin
          len = $urandom_range(13, 40);
        end
        push_frame(8'(len), $urandom_range(0, 4) != 0, $urandom_range(0, 29) == 0);
        frames++;
      end else if (r < 82) begin
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          push_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        push_broken_header();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver: load a byte when the slot is free, wait a drawn gap
  // between bytes, and hold flagged bytes until nothing is owed
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      tx_wait   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_byte(in_tdata);
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_tvalid <= 1'b0;
        end else if (tx_bytes.size() != 0 &&
                     !(tx_hold[0] && due_words.size() != 0)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= tx_bytes.pop_front();
          void'(tx_hold.pop_front());
          // Every third stretch of 90 bytes runs back to back
          tx_wait   = ((bytes_loaded / 90) % 3 == 2) ? 0 : $urandom_range(0, 10);
          bytes_loaded++;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: check each accepted word against the oldest one owed,
  // then stall tready for a drawn number of cycles
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_words.size() == 0) begin
          report_mismatch($sformatf("word with nothing owed: data=%02h last=%0b ok=%0b",
                                    out_tdata, out_tlast, out_tuser));
        end else begin
          want = due_words.pop_front();
          if (out_tdata !== want.data) begin
            report_mismatch($sformatf("data_byte %02h, want %02h", out_tdata, want.data));
          end
          if (out_tlast !== want.last) begin
            report_mismatch($sformatf("frame_end %0b, want %0b (data %02h)",
                                      out_tlast, want.last, want.data));
          end
          if (out_tuser !== want.ok) begin
            report_mismatch($sformatf("frame_ok %0b, want %0b (data %02h)",
                                      out_tuser, want.ok, want.data));
          end
          if (want.last) begin
            if (want.ok) frames_good++;
            else         frames_bad++;
          end
        end
        words_seen++;
        // Every third stretch of 70 words is taken without stalls
        rx_wait = ((words_seen / 70) % 3 == 1) ? 0 : $urandom_range(0, 10);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if neither stream moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles, %0d still owed",
                 STALL_LIMIT, due_words.size());
        $display("tb_sync_header_frame_deframer failed");
        $finish;
      end
    end
  end

  // Sequence the run: fill the queue, reset, drain, judge
  initial begin
    build_stimulus();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (tx_bytes.size() != 0 || in_tvalid || due_words.size() != 0) begin
      @(posedge clk);
    end
    // Linger so that any stray word shows up
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d input bytes and %0d output words", bytes_taken, words_seen);
    $display("frames closed: %0d with good checksum, %0d with bad checksum",
             frames_good, frames_bad);
    if (err_count == 0) begin
      $display("tb_sync_header_frame_deframer passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb_sync_header_frame_deframer failed");
    end
    $finish;
  end

endmodule : tb_sync_header_frame_deframer
`default_nettype wire
